>>> rtl/crt_pkg.sv
// Shared types, codes and constants for the context region energy texture block.
package crt_pkg;

	localparam int ROW_W          = 6;
	localparam int FRAME_W        = 10;
	localparam int SAMPLE_W       = 16;
	localparam int OFS_W          = 8;
	localparam int AREA_W         = 15;
	localparam int NORM_W         = 32;
	localparam int TEX_W          = 40;
	localparam int CFG_W          = 10;
	localparam int CFG_IDX_W      = 3;

	localparam int NUM_SCALES_DEF  = 64;
	localparam int NUM_FRAMES_DEF  = 1024;
	localparam int OFFSET_BITS_DEF = 8;

	localparam logic [TEX_W-1:0] TEX_MAX = {1'b0, {(TEX_W-1){1'b1}}};
	localparam logic [TEX_W-1:0] TEX_MIN = {1'b1, {(TEX_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REQ_SAMPLE   = 2'd0,
		REQ_INTERVAL = 2'd1,
		REQ_NORM     = 2'd2,
		REQ_QUERY    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_DIVZERO = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NORM_EN     = 3'd0,
		CFG_FIRST_FRAME = 3'd1,
		CFG_LAST_FRAME  = 3'd2,
		CFG_FIRST_SCALE = 3'd3,
		CFG_LAST_SCALE  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [AREA_W-1:0]        area;
		logic signed [NORM_W-1:0] mean;
		logic [NORM_W-1:0]        sigma;
	} norm_t;

	localparam norm_t NORM_RST = '{area: 15'd1, mean: 32'sd0, sigma: 32'h4000_0000};

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

>>> rtl/context_region_energy_texture_core.sv
// Top level of the context region energy texture block: sequencer, accumulator, config.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------------
//  request   | start / busy           | req_type, row, context_row, frame_index,
//            |                        | sample_value, start_offset, end_offset,
//            |                        | area_count, mean_value, sigma_value
//  result    | done (one-cycle pulse) | texture, status
//  config    | cfg_we                 | cfg_index, cfg_wdata
//
// Loads and out-of-range queries finish at acceptance; the result pulses in the cycle after.
// A query reads the interval of each context row (S_IRD, S_IWT), then steps through every
// frame of each non-empty interval (single sample-store read port), drains the sample
// pipeline, then runs the area divide and, with normalisation on, the sigma divide
// (bit-serial, N = 77 at defaults). After reset the block sweeps the sample and interval
// stores to zero, one entry a cycle, holding busy high.
// Results are never stalled: the receiver takes each transaction as it pulses.
module context_region_energy_texture_core #(
	parameter int NUM_SCALES  = crt_pkg::NUM_SCALES_DEF,
	parameter int NUM_FRAMES  = crt_pkg::NUM_FRAMES_DEF,
	parameter int OFFSET_BITS = crt_pkg::OFFSET_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               cfg_we,
	input  logic [crt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crt_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic [1:0]                         req_type,
	input  logic [crt_pkg::ROW_W-1:0]          row,
	input  logic [crt_pkg::ROW_W-1:0]          context_row,
	input  logic [crt_pkg::FRAME_W-1:0]        frame_index,
	input  logic signed [crt_pkg::SAMPLE_W-1:0] sample_value,
	input  logic signed [crt_pkg::OFS_W-1:0]   start_offset,
	input  logic signed [crt_pkg::OFS_W-1:0]   end_offset,
	input  logic [crt_pkg::AREA_W-1:0]         area_count,
	input  logic signed [crt_pkg::NORM_W-1:0]  mean_value,
	input  logic [crt_pkg::NORM_W-1:0]         sigma_value,
	output logic                               done,
	output logic signed [crt_pkg::TEX_W-1:0]   texture,
	output logic [1:0]                         status
);
	import crt_pkg::*;

	localparam int SB    = $clog2(NUM_SCALES);
	localparam int FB    = $clog2(NUM_FRAMES);
	localparam int OB    = OFFSET_BITS;
	localparam int CUR_W = imax(imax(FRAME_W, OB), FB) + 2;
	localparam int SUM_W = 31 + SB + OB;
	localparam int A_W   = SUM_W + 2;
	localparam int D_W   = A_W + 1;
	localparam int DIV_N = A_W + 30;
	localparam int CMP_W = 18;

	localparam logic [CUR_W-1:0] NF_C   = CUR_W'(NUM_FRAMES);
	localparam logic [SB-1:0]    R_LAST = SB'(NUM_SCALES - 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_IRD  = 9'b000000010,
		S_IWT  = 9'b000000100,
		S_SMP  = 9'b000001000,
		S_DRN  = 9'b000010000,
		S_DIV1 = 9'b000100000,
		S_WT1  = 9'b001000000,
		S_NRM  = 9'b010000000,
		S_WT2  = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic             norm_en_q;
	logic [FRAME_W-1:0] ff_q, lf_q;
	logic [ROW_W-1:0] fs_q, ls_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_en_q <= 1'b0;
			ff_q      <= '0;
			lf_q      <= '1;
			fs_q      <= '0;
			ls_q      <= '1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NORM_EN:     norm_en_q <= cfg_wdata[0];
				CFG_FIRST_FRAME: ff_q      <= cfg_wdata;
				CFG_LAST_FRAME:  lf_q      <= cfg_wdata;
				CFG_FIRST_SCALE: fs_q      <= cfg_wdata[ROW_W-1:0];
				CFG_LAST_SCALE:  ls_q      <= cfg_wdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// request decode
	logic clearing, accept;
	logic row_ok, crow_ok, frame_ok, q_valid;

	assign busy     = clearing || (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign row_ok   = CMP_W'(row) < CMP_W'(NUM_SCALES);
	assign crow_ok  = CMP_W'(context_row) < CMP_W'(NUM_SCALES);
	assign frame_ok = CMP_W'(frame_index) < CMP_W'(NUM_FRAMES);
	assign q_valid  = row_ok && (row >= fs_q) && (row <= ls_q)
		&& (frame_index >= ff_q) && (frame_index <= lf_q);

	logic [7:0] so_raw, eo_raw;
	assign so_raw = start_offset;
	assign eo_raw = end_offset;

	// query working registers
	logic [SB-1:0]      scale_q, r_q;
	logic [FRAME_W-1:0] center_q;
	logic [CUR_W-1:0]   cur_q, hi_q;
	logic [SUM_W-1:0]   acc_q;
	logic [A_W-1:0]     a_q;
	logic               neg_q;
	logic               rd_v_s1, inr_s1, v_s2;
	logic [30:0]        sq_s2;

	// memory ports
	logic signed [SAMPLE_W-1:0] smp_rdata;
	logic [2*OB-1:0]            ivl_rdata;
	norm_t                      nrm;
	norm_t                      nrm_wr;

	assign nrm_wr = '{area: area_count, mean: mean_value, sigma: sigma_value};

	crt_mem #(
		.NUM_SCALES  (NUM_SCALES),
		.NUM_FRAMES  (NUM_FRAMES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.smp_we     (accept && req_t'(req_type) == REQ_SAMPLE && row_ok && frame_ok),
		.smp_wrow   (SB'(row)),
		.smp_wframe (FB'(frame_index)),
		.smp_wdata  (sample_value),
		.smp_rrow   (r_q),
		.smp_rframe (cur_q[FB-1:0]),
		.smp_rdata  (smp_rdata),
		.ivl_we     (accept && req_t'(req_type) == REQ_INTERVAL && row_ok && crow_ok),
		.ivl_wown   (SB'(row)),
		.ivl_wcrow  (SB'(context_row)),
		.ivl_wdata  ({OB'(so_raw), OB'(eo_raw)}),
		.ivl_rown   (scale_q),
		.ivl_rcrow  (r_q),
		.ivl_rdata  (ivl_rdata),
		.nrm_we     (accept && req_t'(req_type) == REQ_NORM && row_ok),
		.nrm_widx   (SB'(row)),
		.nrm_wdata  (nrm_wr),
		.nrm_ridx   (scale_q),
		.nrm_rdata  (nrm)
	);

	// interval bounds, frame cursor
	logic signed [OB-1:0] ivl_lo, ivl_hi;
	logic [CUR_W-1:0]     lo_abs, hi_abs;
	logic                 cur_in;

	assign ivl_lo = ivl_rdata[2*OB-1:OB];
	assign ivl_hi = ivl_rdata[OB-1:0];
	assign lo_abs = CUR_W'(center_q) + CUR_W'(ivl_lo);
	assign hi_abs = CUR_W'(center_q) + CUR_W'(ivl_hi);
	assign cur_in = !cur_q[CUR_W-1] && (cur_q < NF_C);

	// normalisation arithmetic
	logic signed [D_W-1:0] d_val;
	logic [A_W-1:0]        mag;
	assign d_val = $signed({1'b0, a_q}) - (D_W'(nrm.mean) <<< 2);
	assign mag   = d_val[D_W-1] ? A_W'(-d_val) : A_W'(d_val);

	// shared divider
	logic             div_start, div_done;
	logic [DIV_N-1:0] div_dvd, div_quo;
	logic [NORM_W-1:0] div_dvs;

	assign div_start = ((state_q == S_DIV1) && nrm.area != '0)
		|| ((state_q == S_NRM) && nrm.sigma != '0);
	assign div_dvd   = (state_q == S_NRM) ? {mag, 30'd0} : DIV_N'({acc_q, 2'b00});
	assign div_dvs   = (state_q == S_NRM) ? nrm.sigma : NORM_W'(nrm.area);

	crt_div #(.N(DIV_N)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sample pipeline: read, square, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_SMP);
			v_s2    <= rd_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		inr_s1 <= cur_in;
		sq_s2  <= inr_s1 ? 31'(smp_rdata * smp_rdata) : '0;
	end

	// result registers and sequencer
	logic               done_q;
	logic [TEX_W-1:0]   tex_q;
	status_t            status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			tex_q    <= '0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_t'(req_type) != REQ_QUERY || !q_valid) begin
							done_q   <= 1'b1;
							tex_q    <= '0;
							status_q <= (req_t'(req_type) == REQ_QUERY) ? ST_RANGE : ST_OK;
						end else begin
							state_q <= S_IRD;
						end
					end
				end
				S_IRD: state_q <= S_IWT;
				S_IWT: begin
					if (ivl_lo < ivl_hi) state_q <= S_SMP;
					else if (r_q == R_LAST) state_q <= S_DRN;
					else state_q <= S_IRD;
				end
				S_SMP: begin
					if (cur_q == hi_q) state_q <= (r_q == R_LAST) ? S_DRN : S_IRD;
				end
				S_DRN: begin
					if (!rd_v_s1 && !v_s2) state_q <= S_DIV1;
				end
				S_DIV1: begin
					if (nrm.area == '0) begin
						done_q   <= 1'b1;
						tex_q    <= TEX_MAX;
						status_q <= ST_DIVZERO;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_WT1;
					end
				end
				S_WT1: begin
					if (div_done) begin
						if (norm_en_q) begin
							state_q <= S_NRM;
						end else begin
							done_q   <= 1'b1;
							status_q <= ST_OK;
							tex_q    <= (div_quo[A_W-1:TEX_W-1] != '0) ? TEX_MAX
								: div_quo[TEX_W-1:0];
							state_q  <= S_IDLE;
						end
					end
				end
				S_NRM: begin
					if (nrm.sigma == '0) begin
						done_q   <= 1'b1;
						tex_q    <= d_val[D_W-1] ? TEX_MIN : TEX_MAX;
						status_q <= ST_DIVZERO;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_WT2;
					end
				end
				S_WT2: begin
					if (div_done) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						if (div_quo[DIV_N-1:TEX_W-1] != '0) tex_q <= neg_q ? TEX_MIN : TEX_MAX;
						else if (neg_q) tex_q <= TEX_W'(-div_quo[TEX_W-1:0]);
						else tex_q <= div_quo[TEX_W-1:0];
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// query datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			scale_q  <= SB'(row);
			center_q <= frame_index;
			r_q      <= '0;
			acc_q    <= '0;
		end else begin
			if (v_s2) acc_q <= acc_q + SUM_W'(sq_s2);
			if (state_q == S_IWT) begin
				cur_q <= lo_abs;
				hi_q  <= hi_abs;
				if (!(ivl_lo < ivl_hi) && r_q != R_LAST) r_q <= r_q + 1'b1;
			end
			if (state_q == S_SMP) begin
				cur_q <= cur_q + 1'b1;
				if (cur_q == hi_q && r_q != R_LAST) r_q <= r_q + 1'b1;
			end
			if (state_q == S_WT1 && div_done) a_q <= div_quo[A_W-1:0];
			if (state_q == S_NRM) neg_q <= d_val[D_W-1];
		end
	end

	assign done    = done_q;
	assign texture = tex_q;
	assign status  = status_q;

`ifndef NO_ASSERTIONS
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> busy) else $error("accepting during store sweep");
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_RANGE) |-> texture == '0) else $error("invalid query nonzero");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_RANGE || status == ST_DIVZERO))
		else $error("bad status code");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !$past(div_start)) else $error("divider restarted");
`endif

endmodule

>>> rtl/crt_mem.sv
// Sample store, interval table and per-scale normalisation table with reset sweep.
module crt_mem #(
	parameter int NUM_SCALES  = crt_pkg::NUM_SCALES_DEF,
	parameter int NUM_FRAMES  = crt_pkg::NUM_FRAMES_DEF,
	parameter int OFFSET_BITS = crt_pkg::OFFSET_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	output logic                              clearing,
	input  logic                              smp_we,
	input  logic [$clog2(NUM_SCALES)-1:0]     smp_wrow,
	input  logic [$clog2(NUM_FRAMES)-1:0]     smp_wframe,
	input  logic signed [crt_pkg::SAMPLE_W-1:0] smp_wdata,
	input  logic [$clog2(NUM_SCALES)-1:0]     smp_rrow,
	input  logic [$clog2(NUM_FRAMES)-1:0]     smp_rframe,
	output logic signed [crt_pkg::SAMPLE_W-1:0] smp_rdata,
	input  logic                              ivl_we,
	input  logic [$clog2(NUM_SCALES)-1:0]     ivl_wown,
	input  logic [$clog2(NUM_SCALES)-1:0]     ivl_wcrow,
	input  logic [2*OFFSET_BITS-1:0]          ivl_wdata,
	input  logic [$clog2(NUM_SCALES)-1:0]     ivl_rown,
	input  logic [$clog2(NUM_SCALES)-1:0]     ivl_rcrow,
	output logic [2*OFFSET_BITS-1:0]          ivl_rdata,
	input  logic                              nrm_we,
	input  logic [$clog2(NUM_SCALES)-1:0]     nrm_widx,
	input  crt_pkg::norm_t                    nrm_wdata,
	input  logic [$clog2(NUM_SCALES)-1:0]     nrm_ridx,
	output crt_pkg::norm_t                    nrm_rdata
);
	import crt_pkg::*;

	localparam int SB = $clog2(NUM_SCALES);
	localparam int FB = $clog2(NUM_FRAMES);
	localparam int CW = imax(SB + FB, 2 * SB);

	logic signed [SAMPLE_W-1:0] smp_mem [2**(SB+FB)];
	logic [2*OFFSET_BITS-1:0]   ivl_mem [2**(2*SB)];
	norm_t                      nrm_mem [NUM_SCALES];
	logic [NUM_SCALES-1:0]      nrm_vld_q;
	logic                       nrm_rvld_q;
	norm_t                      nrm_rraw_q;
	logic                       clr_q;
	logic [CW-1:0]              clr_cnt_q;

	assign clearing = clr_q;

	// reset sweep: one entry of the sample and interval stores per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (&clr_cnt_q) clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) smp_mem[clr_cnt_q[SB+FB-1:0]] <= '0;
		else if (smp_we) smp_mem[{smp_wrow, smp_wframe}] <= smp_wdata;
		smp_rdata <= smp_mem[{smp_rrow, smp_rframe}];
	end

	always_ff @(posedge clk) begin
		if (clr_q) ivl_mem[clr_cnt_q[2*SB-1:0]] <= '0;
		else if (ivl_we) ivl_mem[{ivl_wown, ivl_wcrow}] <= ivl_wdata;
		ivl_rdata <= ivl_mem[{ivl_rown, ivl_rcrow}];
	end

	always_ff @(posedge clk) begin
		if (nrm_we) nrm_mem[nrm_widx] <= nrm_wdata;
		nrm_rraw_q <= nrm_mem[nrm_ridx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_vld_q  <= '0;
			nrm_rvld_q <= 1'b0;
		end else begin
			if (nrm_we) nrm_vld_q[nrm_widx] <= 1'b1;
			nrm_rvld_q <= nrm_vld_q[nrm_ridx];
		end
	end

	assign nrm_rdata = nrm_rvld_q ? nrm_rraw_q : NORM_RST;

endmodule

>>> rtl/crt_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module crt_div #(
	parameter int N = 77
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [N-1:0]                dividend,
	input  logic [crt_pkg::NORM_W-1:0]  divisor,
	output logic                        done,
	output logic [N-1:0]                quotient
);
	import crt_pkg::*;

	localparam int CNT_W = $clog2(N + 1);

	logic                run_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NORM_W-1:0]   rem_q;
	logic [NORM_W-1:0]   dvs_q;
	logic [N-1:0]        quo_q;
	logic [NORM_W:0]     trial;
	logic                fits;

	assign trial = {rem_q, quo_q[N-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(N - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? NORM_W'(trial - {1'b0, dvs_q}) : trial[NORM_W-1:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> verif/tb_context_region_energy_texture_core.sv
// Self-checking testbench for the context region energy texture core.
module tb_context_region_energy_texture_core;
	import crt_pkg::*;

	// one request transaction as seen on the request ports
	typedef struct {
		req_t                    kind;
		logic [ROW_W-1:0]        row;
		logic [ROW_W-1:0]        ctx;
		logic [FRAME_W-1:0]      frame;
		logic signed [15:0]      smp;
		logic signed [7:0]       ofs_lo;
		logic signed [7:0]       ofs_hi;
		logic [AREA_W-1:0]       area;
		logic signed [31:0]      mean;
		logic [31:0]             sigma;
	} request_t;

	typedef struct {
		logic signed [TEX_W-1:0] tex;
		status_t                 st;
	} texture_result_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic                        cfg_we;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]            cfg_wdata;
	logic [1:0]                  req_type;
	logic [ROW_W-1:0]            row;
	logic [ROW_W-1:0]            context_row;
	logic [FRAME_W-1:0]          frame_index;
	logic signed [SAMPLE_W-1:0]  sample_value;
	logic signed [OFS_W-1:0]     start_offset;
	logic signed [OFS_W-1:0]     end_offset;
	logic [AREA_W-1:0]           area_count;
	logic signed [NORM_W-1:0]    mean_value;
	logic [NORM_W-1:0]           sigma_value;
	logic                        done;
	logic signed [TEX_W-1:0]     texture;
	logic [1:0]                  status;

	context_region_energy_texture_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.req_type(req_type), .row(row), .context_row(context_row),
		.frame_index(frame_index), .sample_value(sample_value),
		.start_offset(start_offset), .end_offset(end_offset),
		.area_count(area_count), .mean_value(mean_value), .sigma_value(sigma_value),
		.done(done), .texture(texture), .status(status)
	);

	// shadow copy of the block's stores and registers
	logic signed [15:0] shadow_samples [64][1024];
	int                 span_lo [64][64];
	int                 span_hi [64][64];
	norm_t              shadow_norm [64];
	bit                 norm_en;
	int                 frame_first, frame_last, scale_first, scale_last;

	texture_result_t    pending_textures [$];
	int                 errors;
	bit                 idle_on;

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// energy sum over the context region, area division, optional normalisation
	function automatic texture_result_t region_texture(input int sc, input int ctr);
		texture_result_t   res;
		longint unsigned   total, a32, mag, qh, rem, q, sig;
		longint            d, p, v;
		bit                neg;
		total = 0;
		res.st = ST_OK;
		for (int r = 0; r < 64; r++) begin
			if (span_lo[sc][r] == span_hi[sc][r])
				continue;
			for (int f = ctr + span_lo[sc][r]; f <= ctr + span_hi[sc][r]; f++) begin
				if (f >= 0 && f < 1024) begin
					p = longint'(shadow_samples[r][f]);
					total += p * p;
				end
			end
		end
		if (shadow_norm[sc].area == 0) begin
			res.tex = TEX_MAX;
			res.st = ST_DIVZERO;
			return res;
		end
		a32 = (total * 4) / shadow_norm[sc].area;
		if (!norm_en) begin
			res.tex = (a32 > 64'h7F_FFFF_FFFF) ? TEX_MAX : a32[39:0];
			return res;
		end
		d = longint'(a32) - longint'(shadow_norm[sc].mean) * 4;
		neg = d < 0;
		mag = neg ? -d : d;
		sig = 64'(shadow_norm[sc].sigma);
		if (sig == 0) begin
			res.tex = neg ? TEX_MIN : TEX_MAX;
			res.st = ST_DIVZERO;
			return res;
		end
		qh = mag / sig;
		rem = mag % sig;
		if (qh >= 1024) begin
			res.tex = neg ? TEX_MIN : TEX_MAX;
			return res;
		end
		q = (qh << 30) + (rem << 30) / sig;
		v = neg ? -longint'(q) : longint'(q);
		if (v > 64'sh7F_FFFF_FFFF)
			res.tex = TEX_MAX;
		else if (v < -64'sh80_0000_0000)
			res.tex = TEX_MIN;
		else
			res.tex = v[39:0];
		return res;
	endfunction

	// applies one transaction to the shadow state and gives its result
	function automatic texture_result_t apply_request(input request_t it);
		texture_result_t res;
		res.tex = '0;
		res.st = ST_OK;
		case (it.kind)
			REQ_SAMPLE: shadow_samples[it.row][it.frame] = it.smp;
			REQ_INTERVAL: begin
				span_lo[it.row][it.ctx] = int'(it.ofs_lo);
				span_hi[it.row][it.ctx] = int'(it.ofs_hi);
			end
			REQ_NORM: shadow_norm[it.row] = '{area: it.area, mean: it.mean, sigma: it.sigma};
			default: begin
				if (it.row >= scale_first && it.row <= scale_last &&
				    it.frame >= frame_first && it.frame <= frame_last)
					res = region_texture(it.row, it.frame);
				else
					res.st = ST_RANGE;
			end
		endcase
		return res;
	endfunction

	// called just after a rising edge; leaves start high on acceptance
	task automatic send_request(input request_t it);
		if (idle_on && $urandom_range(99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start        <= 1'b1;
		req_type     <= it.kind;
		row          <= it.row;
		context_row  <= it.ctx;
		frame_index  <= it.frame;
		sample_value <= it.smp;
		start_offset <= it.ofs_lo;
		end_offset   <= it.ofs_hi;
		area_count   <= it.area;
		mean_value   <= it.mean;
		sigma_value  <= it.sigma;
		do @(posedge clk); while (busy);
		pending_textures = {pending_textures, apply_request(it)};
	endtask

	// drop start, let every result drain and the block fall idle
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_textures.size() > 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		case (idx)
			CFG_NORM_EN:     norm_en = val[0];
			CFG_FIRST_FRAME: frame_first = val;
			CFG_LAST_FRAME:  frame_last = val;
			CFG_FIRST_SCALE: scale_first = val;
			default:         scale_last = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic request_t blank(input req_t k, input int r, input int f);
		request_t it;
		it.kind = k; it.row = ROW_W'(r); it.ctx = '0; it.frame = FRAME_W'(f); it.smp = '0;
		it.ofs_lo = '0; it.ofs_hi = '0; it.area = AREA_W'(1); it.mean = '0;
		it.sigma = 32'h4000_0000;
		return it;
	endfunction

	task automatic put_sample(input int r, input int f, input int v);
		request_t it;
		it = blank(REQ_SAMPLE, r, f);
		it.smp = 16'(v);
		send_request(it);
	endtask

	task automatic put_span(input int owner, input int c, input int lo, input int hi);
		request_t it;
		it = blank(REQ_INTERVAL, owner, 0);
		it.ctx = ROW_W'(c); it.ofs_lo = 8'(lo); it.ofs_hi = 8'(hi);
		send_request(it);
	endtask

	task automatic put_norm(input int r, input int a, input longint m, input longint s);
		request_t it;
		it = blank(REQ_NORM, r, 0);
		it.area = AREA_W'(a); it.mean = 32'(m); it.sigma = 32'(s);
		send_request(it);
	endtask

	task automatic ask(input int r, input int f);
		send_request(blank(REQ_QUERY, r, f));
	endtask

	// stores are empty after reset: every in-range query gives zero
	task automatic test_reset_state();
		ask(5, 100);
		ask(63, 1023);
	endtask

	// extreme samples, region edges off the store, empty and inverted spans
	task automatic test_region_sums();
		put_sample(1, 0, 32767);
		put_sample(1, 1, -32768);
		put_sample(1, 2, 1234);
		put_sample(2, 1023, -1);
		put_sample(2, 1000, -32768);
		put_span(3, 1, -2, 0);
		put_span(3, 2, 0, 127);
		put_span(3, 5, 4, 1);      // end below start
		put_span(3, 6, 7, 7);      // empty
		put_span(3, 7, -128, 127);
		ask(3, 2);
		ask(3, 0);
		ask(3, 1000);
		put_norm(3, 3, 0, 32'h4000_0000);
		ask(3, 2);
		put_norm(3, 0, 0, 32'h4000_0000);
		ask(3, 1);                 // zero area saturates
		put_norm(3, 16384, 0, 32'h4000_0000);
		ask(3, 1);
	endtask

	task automatic test_normalisation();
		drain_results();
		write_register(CFG_NORM_EN, 1);
		ask(5, 7);
		put_norm(3, 1, 32'sh7FFF_FFFF, 1);
		ask(3, 1);                 // negative overflow
		put_norm(3, 1, -32'sh8000_0000, 1);
		ask(3, 1);                 // positive overflow
		put_norm(3, 2, 123456, 0);
		ask(3, 1);                 // zero sigma
		put_norm(3, 32767, -77, 32'hFFFF_FFFF);
		ask(3, 2);
		drain_results();
		write_register(CFG_NORM_EN, 0);
	endtask

	task automatic test_valid_region();
		drain_results();
		write_register(CFG_FIRST_FRAME, 1023);
		write_register(CFG_LAST_FRAME, 1023);
		write_register(CFG_FIRST_SCALE, 63);
		write_register(CFG_LAST_SCALE, 63);
		ask(63, 1023);
		ask(63, 1022);
		ask(0, 1023);
		drain_results();
		// crossed bounds: nothing is valid
		write_register(CFG_FIRST_FRAME, 5);
		write_register(CFG_LAST_FRAME, 4);
		ask(3, 4);
		ask(3, 5);
		drain_results();
		write_register(CFG_FIRST_FRAME, 0);
		write_register(CFG_LAST_FRAME, 1023);
		write_register(CFG_FIRST_SCALE, 0);
		write_register(CFG_LAST_SCALE, 63);
	endtask

	// mostly clustered content so that regions actually hold energy
	function automatic request_t random_request();
		request_t it;
		int       pick;
		bit       near;
		it.row = ROW_W'($urandom); it.ctx = ROW_W'($urandom);
		it.frame = FRAME_W'($urandom); it.smp = SAMPLE_W'($urandom);
		it.ofs_lo = OFS_W'($urandom); it.ofs_hi = OFS_W'($urandom);
		it.area = AREA_W'($urandom);
		it.mean = $urandom; it.sigma = $urandom;
		near = $urandom_range(99) < 80;
		pick = $urandom_range(99);
		if (pick < 30) begin
			it.kind = REQ_SAMPLE;
			if (near) begin
				it.row = ROW_W'($urandom_range(7));
				it.frame = FRAME_W'($urandom_range(490, 550));
			end
		end else if (pick < 45) begin
			it.kind = REQ_INTERVAL;
			if (near) begin
				it.row = ROW_W'($urandom_range(3));
				it.ctx = ROW_W'($urandom_range(7));
				it.ofs_lo = OFS_W'($urandom_range(16) - 8);
				it.ofs_hi = OFS_W'($urandom_range(16) - 8);
			end
		end else if (pick < 55) begin
			it.kind = REQ_NORM;
			if (near) begin
				it.row = ROW_W'($urandom_range(3));
				it.area = AREA_W'($urandom_range(64));
				it.mean = $urandom_range(1 << 20) - (1 << 19);
				it.sigma = $urandom_range(32'h4000_0000, 32'h1000_0000);
			end
		end else begin
			it.kind = REQ_QUERY;
			if (near) begin
				it.row = ROW_W'($urandom_range(3));
				it.frame = FRAME_W'($urandom_range(500, 540));
			end
		end
		return it;
	endfunction

	task automatic test_random_traffic();
		int lo, hi;
		for (int n = 0; n < 70; n++) begin
			if (n == 30) begin
				drain_results();
				write_register(CFG_NORM_EN, 1);
				lo = $urandom_range(520);
				hi = $urandom_range(1023, 510);
				write_register(CFG_FIRST_FRAME, lo);
				write_register(CFG_LAST_FRAME, hi);
				write_register(CFG_FIRST_SCALE, $urandom_range(1));
				write_register(CFG_LAST_SCALE, $urandom_range(63, 2));
			end
			if (n == 40)
				drain_results();   // sender holds off until all results are in
			if (n == 45)
				idle_on = 1'b0;
			if (n == 65)
				idle_on = 1'b1;
			send_request(random_request());
		end
	endtask

	// every result pulse is taken at once; compare with the oldest prediction
	always @(posedge clk) begin
		texture_result_t want;
		if (arst_n && done) begin
			if (pending_textures.size() == 0) begin
				report_mismatch("unexpected transaction", texture, 0);
			end else begin
				want = pending_textures.pop_front();
				if (texture !== want.tex)
					report_mismatch("texture", texture, want.tex);
				if (status !== want.st)
					report_mismatch("status", status, want.st);
			end
		end
	end

	initial begin
		errors = 0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
		req_type = '0; row = '0; context_row = '0; frame_index = '0;
		sample_value = '0; start_offset = '0; end_offset = '0;
		area_count = '0; mean_value = '0; sigma_value = '0;
		for (int r = 0; r < 64; r++) begin
			shadow_norm[r] = NORM_RST;
			for (int f = 0; f < 1024; f++)
				shadow_samples[r][f] = 0;
			for (int c = 0; c < 64; c++) begin
				span_lo[r][c] = 0;
				span_hi[r][c] = 0;
			end
		end
		norm_en = 0; frame_first = 0; frame_last = 1023; scale_first = 0; scale_last = 63;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// store clearing sweep keeps busy high
		repeat (2) @(posedge clk);
		while (busy) @(posedge clk);

		test_reset_state();
		test_region_sums();
		test_normalisation();
		test_valid_region();
		test_random_traffic();

		start <= 1'b0;
		@(posedge clk);
		while (pending_textures.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
rtl/crt_pkg.sv
rtl/crt_mem.sv
rtl/crt_div.sv
rtl/context_region_energy_texture_core.sv
verif/tb_context_region_energy_texture_core.sv
